### rtl/spmv_pkg.sv
// ----------------------------------------------------------------------------
// spmv_pkg: shared definitions for the sparse matrix-vector multiplier
// Field widths, command codes, configuration register indexes and defaults.
// ----------------------------------------------------------------------------
package spmv_pkg;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 10;
    localparam int VAL_W   = 32;
    localparam int ROW_W   = 10;
    localparam int ROWS_W  = 11;
    localparam int ACC_W   = 64;
    localparam int CFG_W   = 11;

    localparam int VEC_DEPTH_DEF = 1024;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [0:0]        t_cfg_index;
    typedef logic [CFG_W-1:0]  t_cfg_data;

    localparam t_cmd CMD_LOAD  = 2'd0;
    localparam t_cmd CMD_NZ    = 2'd1;
    localparam t_cmd CMD_EMPTY = 2'd2;

    localparam t_cfg_index CFG_ACC_MODE  = 1'd0;
    localparam t_cfg_index CFG_ROW_COUNT = 1'd1;

    localparam logic [ROWS_W-1:0] ROW_COUNT_RST = 11'd1024;

    // control that travels with an item down the pipe
    typedef struct packed {
        logic                    empty;
        logic                    last;
        logic signed [VAL_W-1:0] prior;
    } t_ctl;

endpackage

### rtl/spmv_in_if.sv
// ----------------------------------------------------------------------------
// spmv_in_if: input item channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface spmv_in_if;
    import spmv_pkg::*;

    logic                    valid;
    logic                    ready;
    t_cmd                    command;
    t_pos                    position;
    logic signed [VAL_W-1:0] operand_value;
    logic                    row_last;
    logic signed [VAL_W-1:0] prior_result;

    modport source (
        output valid, command, position, operand_value, row_last, prior_result,
        input  ready
    );
    modport sink (
        input  valid, command, position, operand_value, row_last, prior_result,
        output ready
    );
endinterface

### rtl/spmv_out_if.sv
// ----------------------------------------------------------------------------
// spmv_out_if: row result channel
// Valid/ready channel carrying one finished row beat.
// ----------------------------------------------------------------------------
interface spmv_out_if;
    import spmv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] row_value;
    t_row                    row_number;
    logic                    saturated;

    modport source (
        output valid, row_value, row_number, saturated,
        input  ready
    );
    modport sink (
        input  valid, row_value, row_number, saturated,
        output ready
    );
endinterface

### rtl/sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply: row-streamed y = A*x in Q16.16
// Vector store, multiply, round and saturating 64-bit accumulate per row.
// ----------------------------------------------------------------------------
// One item is taken every cycle unless the pipe stalls. Each beat goes
// through four registers: the vector store read (one read port, addressed
// straight from the input beat), the 32x32 multiply, the rounding add, and
// the accumulate step, which closes the row into the output register. The
// accumulate step is the only loop: the row sum is fed back from its own
// register, so the rate stays at one item per cycle. Stages hold only when
// the output register is full and not taken; empty stages still take new
// beats. The vector store is not cleared after reset; entries must be
// loaded before they are used.
module sparse_matrix_vector_multiply #(
    parameter int VEC_DEPTH = spmv_pkg::VEC_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    spmv_in_if.sink                i_in,
    spmv_out_if.source             o_out,
    input  logic                   i_cfg_we,
    input  spmv_pkg::t_cfg_index   i_cfg_index,
    input  spmv_pkg::t_cfg_data    i_cfg_data
);
    import spmv_pkg::*;

    localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int CW = (AW > POS_W) ? AW + 1 : POS_W + 1;

    // configuration
    logic              r_acc;
    logic [ROWS_W-1:0] r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= 1'b0;
            r_rows <= ROW_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACC_MODE:  r_acc  <= i_cfg_data[0];
                CFG_ROW_COUNT: r_rows <= i_cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline valids and handshake
    logic r_v1, r_v2, r_v3;
    logic r_ov;
    logic w_out_free, w_rdy3, w_rdy2, w_rdy1, w_acc_in;

    assign w_out_free = !r_ov || o_out.ready;
    assign w_rdy3     = !r_v3 || w_out_free;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;
    assign w_acc_in   = i_in.valid && w_rdy1;

    // vector store
    logic signed [VAL_W-1:0] r_mem [VEC_DEPTH];
    logic [AW-1:0]           w_addr;
    logic                    w_in_range;

    assign w_addr     = AW'(i_in.position);
    assign w_in_range = CW'(i_in.position) < CW'(VEC_DEPTH);

    logic signed [VAL_W-1:0] r_x;
    logic                    r_xok;

    always_ff @(posedge i_clk) begin
        if (w_acc_in && i_in.command == CMD_LOAD && w_in_range) begin
            r_mem[w_addr] <= i_in.operand_value;
        end
        if (w_acc_in && i_in.command == CMD_NZ && w_in_range) begin
            r_x <= r_mem[w_addr];
        end
    end

    // stage 1: operands
    logic signed [VAL_W-1:0] r_val;
    t_ctl                    r_ctl1, r_ctl2, r_ctl3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= w_acc_in &&
                    (i_in.command == CMD_NZ || i_in.command == CMD_EMPTY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_val        <= i_in.operand_value;
            r_xok        <= w_in_range;
            r_ctl1.empty <= (i_in.command == CMD_EMPTY);
            r_ctl1.last  <= i_in.row_last;
            r_ctl1.prior <= i_in.prior_result;
        end
    end

    // stage 2: product
    logic signed [VAL_W-1:0] w_x;
    logic signed [ACC_W-1:0] r_prod;

    assign w_x = r_xok ? r_x : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_prod <= r_val * w_x;
            r_ctl2 <= r_ctl1;
        end
    end

    // stage 3: round half up to Q16.16
    logic signed [ACC_W-1:0] w_rnd_pre;
    logic signed [ACC_W-1:0] r_rnd;

    assign w_rnd_pre = r_prod + 64'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_rnd  <= w_rnd_pre >>> 16;
            r_ctl3 <= r_ctl2;
        end
    end

    // accumulate and close
    logic signed [ACC_W-1:0] r_sum;
    logic                    r_open;
    t_row                    r_cnt;
    logic signed [ACC_W-1:0] w_base, w_add, n_sum;
    logic                    w_ovf, w_close, w_fits, w_step;
    logic [ROWS_W-1:0]       w_inc;
    t_row                    n_cnt;

    assign w_base = r_open ? r_sum : (r_acc ? ACC_W'(r_ctl3.prior) : '0);
    assign w_add  = w_base + r_rnd;
    // signed overflow: operands agree in sign, sum does not
    assign w_ovf  = (w_base[ACC_W-1] == r_rnd[ACC_W-1]) &&
                    (w_add[ACC_W-1] != w_base[ACC_W-1]);

    always_comb begin
        if (r_ctl3.empty) begin
            n_sum = w_base;
        end else if (w_ovf) begin
            n_sum = w_base[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                    : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_sum = w_add;
        end
    end

    assign w_close = r_ctl3.empty || r_ctl3.last;
    assign w_step  = r_v3 && w_out_free;
    assign w_fits  = (&n_sum[ACC_W-1:VAL_W-1]) || !(|n_sum[ACC_W-1:VAL_W-1]);
    assign w_inc   = {1'b0, r_cnt} + 11'd1;
    assign n_cnt   = (w_inc >= r_rows) ? '0 : w_inc[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_open <= 1'b0;
            r_cnt  <= '0;
        end else if (w_step) begin
            if (w_close) begin
                r_sum  <= '0;
                r_open <= 1'b0;
                r_cnt  <= n_cnt;
            end else begin
                r_sum  <= n_sum;
                r_open <= 1'b1;
            end
        end
    end

    // output register
    logic signed [VAL_W-1:0] r_oval;
    t_row                    r_orow;
    logic                    r_osat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_free) begin
            r_ov <= w_step && w_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_close) begin
            r_orow <= r_cnt;
            r_osat <= !w_fits;
            if (w_fits) begin
                r_oval <= n_sum[VAL_W-1:0];
            end else if (n_sum[ACC_W-1]) begin
                r_oval <= {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                r_oval <= {1'b0, {(VAL_W-1){1'b1}}};
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.row_value  = r_oval;
    assign o_out.row_number = r_orow;
    assign o_out.saturated  = r_osat;

    // checks
    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_osat) |->
            (r_oval == {1'b0, {(VAL_W-1){1'b1}}} ||
             r_oval == {1'b1, {(VAL_W-1){1'b0}}}))
        else $error("saturated beat without a clamped value");

    a_load_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && i_in.command == CMD_LOAD) |=> !r_v1)
        else $error("vector load entered the multiply pipe");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_close) |=> (!r_open && r_ov))
        else $error("row close did not clear the row or post a result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_ov && !r_v1 && !r_open))
        else $error("pipeline not idle after reset");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for sparse_matrix_vector_multiply
// Loads the dense vector, streams matrix rows as nonzero, empty-row and
// unused-command beats, predicts each finished row in Q16.16 with a 64-bit
// saturating sum, and checks every row beat in order. A short directed part
// covers the field extremes, rounding, saturation and the row-number wrap. A
// random part follows, under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import spmv_pkg::*;

    typedef logic signed [VAL_W-1:0] q16_t;

    typedef struct packed {
        q16_t value;
        t_row row;
        logic sat;
    } row_result_t;

    localparam t_cmd CMD_UNUSED  = 2'd3;
    localparam int   DRAIN_CYCLES = 8;     // lets the pipe drain after the last expected row
    localparam int   STALL_LIMIT  = 1000;
    localparam int   SHOWN_LIMIT  = 10;

    localparam logic signed [ACC_W-1:0] SUM_MIN32 = -64'sd2147483648;
    localparam logic signed [ACC_W-1:0] SUM_MAX32 = 64'sd2147483647;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    t_cfg_index cfg_index;
    t_cfg_data  cfg_data;

    spmv_in_if  item_ch ();
    spmv_out_if row_ch ();

    sparse_matrix_vector_multiply DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (item_ch),
        .o_out       (row_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // row sum predictor
    // ------------------------------------------------------------------------
    q16_t                    x_mem [VEC_DEPTH_DEF];
    bit                      x_written [VEC_DEPTH_DEF];
    t_pos                    loaded_cols [$];
    logic signed [ACC_W-1:0] row_sum = '0;
    bit                      row_open = 1'b0;
    t_row                    row_ctr = '0;
    bit                      mode_acc = 1'b0;
    logic [ROWS_W-1:0]       rows_per_wrap = ROW_COUNT_RST;
    row_result_t             expected_rows [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int items_sent   = 0;
    int rows_checked = 0;
    int sat_rows     = 0;
    int full_wraps   = 0;
    int mismatches   = 0;
    int stall_cycles = 0;

    function automatic void open_row(input q16_t prior);
        if (!row_open) begin
            if (mode_acc)
                row_sum = ACC_W'(prior);
            else
                row_sum = '0;
            row_open = 1'b1;
        end
    endfunction

    function automatic void close_row();
        row_result_t res;
        if (row_sum >= SUM_MIN32 && row_sum <= SUM_MAX32) begin
            res.value = row_sum[VAL_W-1:0];
            res.sat   = 1'b0;
        end else begin
            res.value = row_sum[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            res.sat   = 1'b1;
        end
        res.row = row_ctr;
        expected_rows.push_back(res);
        if (row_ctr == 10'd1023)
            full_wraps++;
        if (int'(row_ctr) + 1 >= int'(rows_per_wrap))
            row_ctr = '0;
        else
            row_ctr = row_ctr + 1'b1;
        row_sum  = '0;
        row_open = 1'b0;
    endfunction

    function automatic void advance_row_sum(input t_cmd cmd, input t_pos pos,
                                            input q16_t val, input logic last,
                                            input q16_t prior);
        logic signed [ACC_W-1:0] opnd;
        logic signed [ACC_W-1:0] xval;
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-1:0] sum_next;
        case (cmd)
            CMD_LOAD: begin
                if (!x_written[pos]) begin
                    x_written[pos] = 1'b1;
                    loaded_cols.push_back(pos);
                end
                x_mem[pos] = val;
            end
            CMD_NZ: begin
                open_row(prior);
                opnd = ACC_W'(val);
                xval = ACC_W'(x_mem[pos]);
                // Q32.32 product back to Q16.16, round half up
                rnd = (opnd * xval + 64'sd32768) >>> 16;
                sum_next = row_sum + rnd;
                if (row_sum[ACC_W-1] == rnd[ACC_W-1] &&
                    sum_next[ACC_W-1] != row_sum[ACC_W-1])
                    sum_next = row_sum[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                : {1'b0, {(ACC_W-1){1'b1}}};
                row_sum = sum_next;
                if (last)
                    close_row();
            end
            CMD_EMPTY: begin
                open_row(prior);
                close_row();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // row result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        row_result_t got;
        row_result_t want;
        if (i_rst_n && row_ch.valid && row_ch.ready) begin
            got = '{row_ch.row_value, row_ch.row_number, row_ch.saturated};
            rows_checked++;
            if (got.sat)
                sat_rows++;
            if (expected_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_LIMIT)
                    $display("unexpected row beat: value %h row %0d sat %0b",
                             got.value, got.row, got.sat);
            end else begin
                want = expected_rows.pop_front();
                if (got.value !== want.value || got.row !== want.row ||
                    got.sat !== want.sat) begin
                    mismatches++;
                    if (mismatches <= SHOWN_LIMIT)
                        $display({"row beat mismatch: expected value %h row %0d sat %0b,",
                                  " got value %h row %0d sat %0b"},
                                 want.value, want.row, want.sat,
                                 got.value, got.row, got.sat);
                end
            end
        end
    end

    // sink side back-pressure
    always @(negedge i_clk)
        row_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    // watchdog: too long without any beat or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (item_ch.valid && item_ch.ready) ||
            (row_ch.valid && row_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d rows still expected",
                     stall_cycles, expected_rows.size());
            $display("end of test: mismatches");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------
    task automatic send_beat(input t_cmd cmd, input t_pos pos, input q16_t val,
                             input logic last, input q16_t prior);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.command       <= cmd;
        item_ch.position      <= pos;
        item_ch.operand_value <= val;
        item_ch.row_last      <= last;
        item_ch.prior_result  <= prior;
        do @(posedge i_clk); while (!item_ch.ready);
        advance_row_sum(cmd, pos, val, last, prior);
        if (cmd != CMD_UNUSED)
            items_sent++;
        @(negedge i_clk);
    endtask

    // no beat in flight and the pipe flushed
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_cfg_data data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ACC_MODE:  mode_acc = data[0];
            CFG_ROW_COUNT: rows_per_wrap = data[ROWS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic q16_t rand_q16();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(4))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return '0;
                3: return '1;
                default: return 32'sh0001_0000;
            endcase
        end
        if (sel < 40)
            return q16_t'($urandom());
        return q16_t'(int'($urandom_range(2097152)) - 1048576);   // within +/-16.0
    endfunction

    // only columns already loaded are ever read
    function automatic t_pos rand_col();
        return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
    endfunction

    task automatic send_load();
        send_beat(CMD_LOAD, t_pos'($urandom_range(1023)), rand_q16(),
                  1'($urandom_range(1)), q16_t'($urandom()));
    endtask

    task automatic send_random_row(input int max_nz);
        int  n;
        int  k;
        bit  close_by_empty;
        n = ($urandom_range(99) < 20) ? 0 : $urandom_range(1, max_nz);
        close_by_empty = ($urandom_range(99) < 10);
        if (n == 0) begin
            send_beat(CMD_EMPTY, t_pos'($urandom()), q16_t'($urandom()),
                      1'($urandom_range(1)), rand_q16());
            return;
        end
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 10)
                send_load();
            if ($urandom_range(99) < 3)
                send_beat(CMD_UNUSED, t_pos'($urandom()), q16_t'($urandom()),
                          1'($urandom_range(1)), q16_t'($urandom()));
            send_beat(CMD_NZ, rand_col(), rand_q16(),
                      (k == n - 1) && !close_by_empty, rand_q16());
        end
        if (close_by_empty)
            send_beat(CMD_EMPTY, t_pos'($urandom()), q16_t'($urandom()),
                      1'($urandom_range(1)), rand_q16());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_vector_load_and_rows();
        send_beat(CMD_LOAD, 10'd5,    32'sh0001_0000, 1'b0, '0);
        send_beat(CMD_LOAD, 10'd0,    32'sh7FFF_FFFF, 1'b1, '1);
        send_beat(CMD_LOAD, 10'd1023, 32'sh8000_0000, 1'b0, '0);
        send_beat(CMD_LOAD, 10'd6,    32'shFFFF_FFFF, 1'b0, '0);
        // load in the middle of a row, read right behind it
        send_beat(CMD_NZ,   10'd5,    32'sh0001_8000, 1'b0, '0);
        send_beat(CMD_LOAD, 10'd7,    32'sh0002_0000, 1'b0, '0);
        send_beat(CMD_NZ,   10'd7,    32'shFFFF_8000, 1'b1, '0);
    endtask

    task automatic test_value_extremes();
        send_beat(CMD_NZ, 10'd0, 32'sh7FFF_FFFF, 1'b0, '0);
        send_beat(CMD_NZ, 10'd0, 32'sh7FFF_FFFF, 1'b1, '0);
        // big swing that cancels out, row closed by an empty-row beat
        send_beat(CMD_NZ, 10'd1023, 32'sh7FFF_FFFF, 1'b0, '0);
        send_beat(CMD_NZ, 10'd1023, 32'sh8000_0000, 1'b0, '1);
        send_beat(CMD_EMPTY, 10'd1023, '1, 1'b1, '1);
        send_beat(CMD_NZ, 10'd1023, 32'sh7FFF_FFFF, 1'b1, '0);
        // rounding: exact half goes up, just past it goes down
        send_beat(CMD_NZ, 10'd6, 32'sh0000_8000, 1'b0, '0);
        send_beat(CMD_NZ, 10'd6, 32'sh0000_8001, 1'b1, '0);
        send_beat(CMD_UNUSED, '1, '1, 1'b1, '1);
        send_beat(CMD_EMPTY, '0, '0, 1'b0, 32'sh7FFF_FFFF);
    endtask

    task automatic test_accumulate_start();
        write_reg(CFG_ACC_MODE, t_cfg_data'(1));
        send_beat(CMD_EMPTY, '0, '0, 1'b0, 32'sh7FFF_FFFF);
        // prior only counts on the beat that opens the row
        send_beat(CMD_NZ, 10'd5, 32'sh0001_0000, 1'b0, 32'sh8000_0000);
        send_beat(CMD_NZ, 10'd5, 32'sh0001_0000, 1'b1, 32'sh1234_5678);
    endtask

    task automatic test_row_number_short_wrap();
        write_reg(CFG_ROW_COUNT, t_cfg_data'(1));
        send_beat(CMD_EMPTY, '0, '0, 1'b0, rand_q16());
        send_beat(CMD_EMPTY, '0, '0, 1'b0, rand_q16());
        // zero behaves like one
        write_reg(CFG_ROW_COUNT, t_cfg_data'(0));
        send_beat(CMD_EMPTY, '1, '1, 1'b1, rand_q16());
    endtask

    task automatic test_random_rows(input int src_pct, input int snk_pct, input bit acc,
                                    input int rows, input int budget);
        int stop_at;
        write_reg(CFG_ACC_MODE, t_cfg_data'(acc));
        write_reg(CFG_ROW_COUNT, t_cfg_data'(rows));
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 12)
                send_load();
            send_random_row(8);
        end
    endtask

    // short rows back to back until the row number has rolled over past 1023
    task automatic test_row_number_full_wrap();
        int rows_after;
        write_reg(CFG_ACC_MODE, t_cfg_data'(1));
        write_reg(CFG_ROW_COUNT, t_cfg_data'(1024));
        src_idle_pct = 0;
        snk_idle_pct = 0;
        rows_after = 0;
        while (full_wraps == 0 || rows_after < 16) begin
            if (full_wraps != 0)
                rows_after++;
            if ($urandom_range(99) < 10)
                send_load();
            if ($urandom_range(99) < 50)
                send_beat(CMD_EMPTY, t_pos'($urandom()), q16_t'($urandom()),
                          1'($urandom_range(1)), rand_q16());
            else
                send_beat(CMD_NZ, rand_col(), rand_q16(), 1'b1, rand_q16());
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_ACC_MODE;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.command       = CMD_LOAD;
        item_ch.position      = '0;
        item_ch.operand_value = '0;
        item_ch.row_last      = 1'b0;
        item_ch.prior_result  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_vector_load_and_rows();
        test_value_extremes();
        test_accumulate_start();
        test_row_number_short_wrap();
        test_random_rows(30, 78, 1'b1, 7, 180);
        test_random_rows(78, 30, 1'b0, 1024, 180);
        test_row_number_full_wrap();
        wait_idle();

        $display("covered %0d input beats and %0d row results (%0d saturated), %0d rollovers",
                 items_sent, rows_checked, sat_rows, full_wraps);
        $display("settings: accumulate on/off, row_count 0, 1, 7, 1024; idling 30/78, 78/30, none");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
